### rtl/base64_stream_decoder_assert.svh
// Assertion macros shared by the base64 stream decoder modules.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef BASE64_STREAM_DECODER_ASSERT_SVH
`define BASE64_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define B64D_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("base64 decoder same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define B64D_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("base64 decoder next-cycle check failed");

`endif

### rtl/b64d_pkg.sv
// Shared types, constants and the alphabet lookup of the base64 stream decoder.
// No dependencies; imported by every decoder module.
package b64d_pkg;

  localparam int COUNT_WIDTH_DEF = 24;
  localparam int CAP_WIDTH       = 24;
  localparam int QUEUE_DEPTH     = 4;
  localparam int CFG_IDX_W       = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_CAPACITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_ONLY   = 1'd1;

  // Character codes of the standard alphabet.
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
  localparam logic [7:0] CHAR_PLUS    = 8'h2b;
  localparam logic [7:0] CHAR_SLASH   = 8'h2f;
  localparam logic [7:0] CHAR_PAD     = 8'h3d;

  localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
  localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;
  localparam logic [5:0] SEXTET_PLUS       = 6'd62;
  localparam logic [5:0] SEXTET_SLASH      = 6'd63;

  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Work handed from the front to the back: up to three bytes and a status.
  typedef struct packed {
    logic [2:0]      emit;
    logic [2:0][7:0] bytes;
    logic            stat;
    logic            ok;
    logic [CAP_WIDTH-1:0] len;
  } job_t;

  // Returns {valid, sextet}; valid is low for characters outside the alphabet.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      r = {1'b1, 6'(c - CHAR_UPPER_A)};
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      r = {1'b1, 6'(c - CHAR_LOWER_A) + SEXTET_LOWER_BASE};
    end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
      r = {1'b1, 6'(c - CHAR_DIGIT_0) + SEXTET_DIGIT_BASE};
    end else if (c == CHAR_PLUS) begin
      r = {1'b1, SEXTET_PLUS};
    end else if (c == CHAR_SLASH) begin
      r = {1'b1, SEXTET_SLASH};
    end
    return r;
  endfunction

endpackage

### rtl/b64d_front.sv
// Front part: configuration registers, character classification, group
// assembly, byte counting and status. Depends on b64d_pkg and the assert header.
`include "base64_stream_decoder_assert.svh"

module b64d_front #(
  parameter int COUNT_WIDTH = b64d_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [b64d_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [b64d_pkg::CAP_WIDTH-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_char,
  input  logic                           in_present,
  input  logic                           in_end,
  input  logic                           q_full,
  output logic                           push_valid,
  output b64d_pkg::job_t                 push_job
);
  import b64d_pkg::*;

  localparam int EW = ((COUNT_WIDTH > CAP_WIDTH) ? COUNT_WIDTH : CAP_WIDTH) + 1;
  localparam logic [EW-1:0] CNT_MAX = {{(EW-COUNT_WIDTH){1'b0}}, {COUNT_WIDTH{1'b1}}};

  logic [CAP_WIDTH-1:0]   cap_r;
  logic                   count_only_r;
  logic [1:0]             pos_r, pos_nxt;
  logic [17:0]            acc_r, acc_nxt;
  logic                   pad3_r, pad3_nxt;
  logic                   closed_r, closed_nxt;
  logic                   err_r, err_nxt;
  logic [COUNT_WIDTH-1:0] bc_r, bc_nxt;

  logic                   fire;
  logic [6:0]             sx;
  logic                   is_pad;
  logic                   err_mid;
  logic                   pad3_mid;
  logic [5:0]             v;
  logic                   grp_done;
  logic [23:0]            chunk;
  logic [1:0]             pads;
  logic [2:0]             byte_on;
  logic [2:0]             counted;
  logic [2:0]             emit;
  logic                   sat_hit;
  logic [1:0]             inc;
  logic [COUNT_WIDTH-1:0] bc_new;
  logic [EW-1:0]          bc_ext;
  logic [EW-1:0]          cap_ext;
  logic [EW-1:0]          cnt_k [3];
  logic                   ok;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;
  assign cap_ext  = EW'(cap_r);

  always_comb begin
    sx       = sextet_of(in_char);
    is_pad   = (in_char == CHAR_PAD);
    err_mid  = err_r;
    pad3_mid = pad3_r;
    v        = 6'd0;
    if (in_present) begin
      if (closed_r) begin
        err_mid = 1'b1;
      end else if (pos_r < 2'd2) begin
        if (!sx[6]) err_mid = 1'b1;
        else v = sx[5:0];
      end else if (pos_r == 2'd2) begin
        if (is_pad) pad3_mid = 1'b1;
        else if (!sx[6]) err_mid = 1'b1;
        else v = sx[5:0];
      end else begin
        if (pad3_r && !is_pad) err_mid = 1'b1;
        else if (!is_pad && !sx[6]) err_mid = 1'b1;
        else if (!is_pad) v = sx[5:0];
      end
    end

    grp_done = in_present && (pos_r == 2'd3);
    chunk    = {acc_r, v};
    pads     = pad3_r ? 2'd2 : (is_pad ? 2'd1 : 2'd0);
    byte_on  = {grp_done && !err_mid && (pads == 2'd0),
                grp_done && !err_mid && (pads != 2'd2),
                grp_done && !err_mid};

    // The count only grows, so once one byte hits the ceiling all later ones do.
    sat_hit = 1'b0;
    for (int k = 0; k < 3; k++) begin
      cnt_k[k]   = EW'(bc_r) + EW'(k);
      counted[k] = byte_on[k] && (cnt_k[k] < CNT_MAX);
      sat_hit    = sat_hit | (byte_on[k] && (cnt_k[k] >= CNT_MAX));
      emit[k]    = counted[k] && !count_only_r && (cnt_k[k] < cap_ext);
    end
    inc     = {1'b0, counted[0]} + {1'b0, counted[1]} + {1'b0, counted[2]};
    bc_new  = bc_r + COUNT_WIDTH'(inc);
    bc_ext  = EW'(bc_new);

    err_nxt    = err_mid | sat_hit;
    pos_nxt    = pos_r;
    acc_nxt    = acc_r;
    pad3_nxt   = pad3_r;
    closed_nxt = closed_r | (grp_done && (pads != 2'd0));
    if (in_present) begin
      if (pos_r == 2'd3) begin
        pos_nxt  = 2'd0;
        acc_nxt  = 18'd0;
        pad3_nxt = 1'b0;
      end else begin
        pos_nxt  = pos_r + 2'd1;
        acc_nxt  = {acc_r[11:0], v};
        pad3_nxt = pad3_mid;
      end
    end
    bc_nxt = bc_new;

    ok = !err_nxt && (pos_nxt == 2'd0) && (count_only_r || (bc_ext <= cap_ext));

    push_job.emit  = emit;
    push_job.bytes = {chunk[7:0], chunk[15:8], chunk[23:16]};
    push_job.stat  = in_end;
    push_job.ok    = ok;
    push_job.len   = ok ? bc_ext[CAP_WIDTH-1:0] : {CAP_WIDTH{1'b0}};
    push_valid     = fire && ((|emit) || in_end);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r        <= '0;
      count_only_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OUT_CAPACITY: cap_r        <= cfg_wdata;
        CFG_COUNT_ONLY:   count_only_r <= cfg_wdata[0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= 2'd0;
      acc_r    <= 18'd0;
      pad3_r   <= 1'b0;
      closed_r <= 1'b0;
      err_r    <= 1'b0;
      bc_r     <= '0;
    end else if (fire) begin
      if (in_end) begin
        pos_r    <= 2'd0;
        acc_r    <= 18'd0;
        pad3_r   <= 1'b0;
        closed_r <= 1'b0;
        err_r    <= 1'b0;
        bc_r     <= '0;
      end else begin
        pos_r    <= pos_nxt;
        acc_r    <= acc_nxt;
        pad3_r   <= pad3_nxt;
        closed_r <= closed_nxt;
        err_r    <= err_nxt;
        bc_r     <= bc_nxt;
      end
    end
  end

  `B64D_ASSERT_NEXT(a_end_clears_text, fire && in_end, (pos_r == 2'd0) && (bc_r == '0) && !err_r)
  `B64D_ASSERT_NOW(a_failed_group_silent, fire && err_mid, emit == 3'b000)

endmodule

### rtl/b64d_queue.sv
// Short request queue between the front and the back of the decoder.
// Depends on b64d_pkg and the assert header.
`include "base64_stream_decoder_assert.svh"

module b64d_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  b64d_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           pop_valid,
  output b64d_pkg::job_t pop_job
);
  import b64d_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);

  job_t          slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_pop;

  assign full      = (cnt_r == CW'(QUEUE_DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_job   = slot_r[rd_ptr_r];
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !do_pop) cnt_nxt = cnt_r + CW'(1);
    else if (!push && do_pop) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_job;
  end

  `B64D_ASSERT_NOW(a_no_push_when_full, push, !full)

endmodule

### rtl/b64d_back.sv
// Back part: takes queued requests and sends their results one per cycle, while
// out_ready is high, through an output register. Depends on b64d_pkg and the assert header.
`include "base64_stream_decoder_assert.svh"

module b64d_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  b64d_pkg::job_t                 q_job,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_byte,
  output logic                           out_kind,
  output logic                           out_ok,
  output logic [b64d_pkg::CAP_WIDTH-1:0] out_len,
  output logic                           out_last
);
  import b64d_pkg::*;

  job_t                 job_r;
  logic [3:0]           rem_r, rem_nxt;
  logic                 ov_r, ov_nxt;
  logic [7:0]           byte_r, byte_nxt;
  logic                 kind_r, kind_nxt;
  logic                 ok_r, ok_nxt;
  logic [CAP_WIDTH-1:0] len_r, len_nxt;
  logic                 last_r, last_nxt;

  logic                 can_load;
  logic                 take;
  logic [3:0]           pick;
  logic [3:0]           rem_after;

  // Remaining results: bits 0..2 are bytes in order, bit 3 is the status.
  always_comb begin
    can_load  = !ov_r || out_ready;
    take      = (rem_r != 4'd0) && can_load;
    pick      = rem_r & (~rem_r + 4'd1);
    rem_after = rem_r & ~pick;
    q_pop     = q_valid && ((rem_r == 4'd0) || (take && (rem_after == 4'd0)));

    rem_nxt = rem_r;
    if (q_pop) rem_nxt = {q_job.stat, q_job.emit};
    else if (take) rem_nxt = rem_after;

    ov_nxt   = take ? 1'b1 : (out_ready ? 1'b0 : ov_r);
    byte_nxt = byte_r;
    kind_nxt = kind_r;
    ok_nxt   = ok_r;
    len_nxt  = len_r;
    last_nxt = last_r;
    if (take) begin
      last_nxt = (rem_after == 4'd0);
      if (pick[3]) begin
        byte_nxt = 8'd0;
        kind_nxt = KIND_STATUS;
        ok_nxt   = job_r.ok;
        len_nxt  = job_r.len;
      end else begin
        byte_nxt = pick[0] ? job_r.bytes[0] : (pick[1] ? job_r.bytes[1] : job_r.bytes[2]);
        kind_nxt = KIND_BYTE;
        ok_nxt   = 1'b0;
        len_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 4'd0;
      ov_r  <= 1'b0;
    end else begin
      rem_r <= rem_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) job_r <= q_job;
    byte_r <= byte_nxt;
    kind_r <= kind_nxt;
    ok_r   <= ok_nxt;
    len_r  <= len_nxt;
    last_r <= last_nxt;
  end

  assign out_valid = ov_r;
  assign out_byte  = byte_r;
  assign out_kind  = kind_r;
  assign out_ok    = ok_r;
  assign out_len   = len_r;
  assign out_last  = last_r;

  `B64D_ASSERT_NOW(a_popped_request_not_empty, q_pop, (q_job.emit != 3'b000) || q_job.stat)
  `B64D_ASSERT_NOW(a_status_is_last, take && pick[3], rem_after == 4'd0)

endmodule

### rtl/base64_stream_decoder.sv
// Top level of the streaming base64 decoder: front, request queue and back.
// Depends on b64d_pkg, b64d_front, b64d_queue and b64d_back.
//
//  channel | direction | tdata                                   | tuser        | tlast
//  in_     | slave     | text_char[7:0]                          | char_present | end_of_text
//  out_    | master    | out_byte, decode_ok, decoded_length, 0s | item_kind    | last_of_run
//  cfg_    | write     | cfg_index selects register, cfg_wdata   | -            | -
//
// One character is accepted per cycle while the request queue has room.
// Results leave at one per cycle through the output register while out_tready
// is high; an item that completes a group gives up to three bytes plus a status,
// so the output port sets the sustained rate for such items. A request's first
// result passes the queue slot, the back's remaining-results register and the
// output register. Synchronous reset clears all control state; no clearing pass.

module base64_stream_decoder #(
  parameter int COUNT_WIDTH = b64d_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [b64d_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [b64d_pkg::CAP_WIDTH-1:0] cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,  // [7:0] text_char
  input  logic                           in_tuser,  // [0] char_present
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [39:0]                    out_tdata, // [7:0] out_byte, [8] decode_ok,
                                                    // [32:9] decoded_length, [39:33] zero
  output logic                           out_tuser, // [0] item_kind
  output logic                           out_tlast
);
  import b64d_pkg::*;

  logic                 push_valid;
  job_t                 push_job;
  logic                 q_full;
  logic                 q_pop;
  logic                 q_valid;
  job_t                 q_job;
  logic [7:0]           o_byte;
  logic                 o_ok;
  logic [CAP_WIDTH-1:0] o_len;

  b64d_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_char    (in_tdata),
    .in_present (in_tuser),
    .in_end     (in_tlast),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_job   (push_job)
  );

  b64d_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_job   (q_job)
  );

  b64d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (o_byte),
    .out_kind  (out_tuser),
    .out_ok    (o_ok),
    .out_len   (o_len),
    .out_last  (out_tlast)
  );

  assign out_tdata = {7'd0, o_len, o_ok, o_byte};

endmodule

### bench/tb.sv
// Self-checking bench for base64_stream_decoder: directed and random texts, random idling.
// A scoreboard class predicts every byte and status; depends on b64d_pkg and the RTL only.
module tb;
  import b64d_pkg::*;

  typedef struct {
    bit [7:0]  data;
    bit        kind;
    bit        ok;
    bit [23:0] length;
    bit        last;
  } decoded_t;

  typedef struct {
    bit [7:0] c;
    bit       present;
    bit       eot;
  } request_t;

  class decode_scoreboard;
    bit [23:0] capacity;
    bit        count_only;
    bit [1:0]  grp_pos;
    bit [17:0] sextets;
    bit        pad_third;
    bit        pad_closed;
    bit        failed;
    bit [23:0] nbytes;
    decoded_t  decoded_q[$];
    decoded_t  run_q[$];
    int        errors;

    function new();
      capacity   = '0;
      count_only = 1'b0;
      errors     = 0;
      clear_text();
    endfunction

    function void clear_text();
      grp_pos    = '0;
      sextets    = '0;
      pad_third  = 1'b0;
      pad_closed = 1'b0;
      failed     = 1'b0;
      nbytes     = '0;
    endfunction

    function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [23:0] val);
      if (idx == CFG_OUT_CAPACITY) begin
        capacity = val;
      end else begin
        count_only = val[0];
      end
    endfunction

    function int sextet_value(bit [7:0] c);
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) return int'(c - CHAR_UPPER_A);
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) return int'(c - CHAR_LOWER_A) + 26;
      if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) return int'(c - CHAR_DIGIT_0) + 52;
      if (c == CHAR_PLUS) return 62;
      if (c == CHAR_SLASH) return 63;
      return -1;
    endfunction

    function void add_result(bit [7:0] b, bit kind, bit ok, bit [23:0] len);
      decoded_t r;
      r.data   = b;
      r.kind   = kind;
      r.ok     = ok;
      r.length = len;
      r.last   = 1'b0;
      run_q.push_back(r);
    endfunction

    // A full counter fails the text instead of wrapping.
    function void tally_byte(bit [7:0] b);
      if (nbytes == 24'hffffff) begin
        failed = 1'b1;
      end else begin
        if (!count_only && nbytes < capacity) add_result(b, KIND_BYTE, 1'b0, '0);
        nbytes++;
      end
    endfunction

    function void accept_char(bit [7:0] c, bit present, bit eot);
      int        s;
      bit [5:0]  v;
      bit        is_pad;
      bit [23:0] chunk;
      int        pads;
      bit        ok;
      run_q.delete();
      if (present) begin
        is_pad = (c == CHAR_PAD);
        s = sextet_value(c);
        v = '0;
        if (pad_closed) begin
          failed = 1'b1;
        end else if (grp_pos < 2) begin
          if (s < 0) failed = 1'b1; else v = s[5:0];
        end else if (grp_pos == 2) begin
          if (is_pad) pad_third = 1'b1;
          else if (s < 0) failed = 1'b1;
          else v = s[5:0];
        end else begin
          if (pad_third && !is_pad) failed = 1'b1;
          else if (!is_pad && s < 0) failed = 1'b1;
          else if (!is_pad) v = s[5:0];
        end
        if (grp_pos < 3) begin
          sextets = {sextets[11:0], v};
          grp_pos++;
        end else begin
          chunk = {sextets, v};
          pads = pad_third ? 2 : (is_pad ? 1 : 0);
          if (!failed) begin
            tally_byte(chunk[23:16]);
            if (pads < 2 && !failed) tally_byte(chunk[15:8]);
            if (pads == 0 && !failed) tally_byte(chunk[7:0]);
          end
          if (pads != 0) pad_closed = 1'b1;
          grp_pos   = '0;
          sextets   = '0;
          pad_third = 1'b0;
        end
      end
      if (eot) begin
        ok = !failed && grp_pos == 0 && (count_only || nbytes <= capacity);
        add_result('0, KIND_STATUS, ok, ok ? nbytes : 24'd0);
        clear_text();
      end
      if (run_q.size() > 0) run_q[run_q.size()-1].last = 1'b1;
      foreach (run_q[i]) decoded_q.push_back(run_q[i]);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [39:0] data, logic user, logic last);
      decoded_t e;
      if (decoded_q.size() == 0) begin
        $error("result with nothing pending: tdata %h tuser %b tlast %b", data, user, last);
        errors++;
        return;
      end
      e = decoded_q.pop_front();
      compare_field("out_byte", 32'(e.data), 32'(data[7:0]));
      compare_field("item_kind", 32'(e.kind), 32'(user));
      compare_field("decode_ok", 32'(e.ok), 32'(data[8]));
      compare_field("decoded_length", 32'(e.length), 32'(data[32:9]));
      compare_field("last_of_run", 32'(e.last), 32'(last));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CAP_WIDTH-1:0] cfg_wdata = '0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata = '0;  // [7:0] text_char
  logic                 in_tuser = 1'b0; // [0] char_present
  logic                 in_tlast = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [39:0]          out_tdata;      // [7:0] out_byte, [8] decode_ok, [32:9] decoded_length
  logic                 out_tuser;      // [0] item_kind
  logic                 out_tlast;

  decode_scoreboard sb = new();
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  int hold_req = 0;

  base64_stream_decoder dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.accept_char(in_tdata, in_tuser, in_tlast);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser, out_tlast);
  end

  // Result sink: random stalls per result, plus an occasional long hold-off.
  initial begin : sink
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req > 0) begin
        out_tready <= 1'b0;
        repeat (hold_req) @(posedge clk);
        hold_req = 0;
      end
      stall = rx_quiet ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_item(bit [7:0] c, bit present, bit eot);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tuser  <= present;
    in_tlast  <= eot;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_string(string s, bit close);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b1, close && i == s.len() - 1);
  endtask

  // Waits until every pending result is out, then lets the pipeline empty
  // before the registers change.
  task automatic configure(bit [23:0] cap, bit co);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.decoded_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_OUT_CAPACITY;
    cfg_wdata <= cap;
    @(posedge clk);
    sb.write_reg(CFG_OUT_CAPACITY, cap);
    cfg_index <= CFG_COUNT_ONLY;
    cfg_wdata <= {23'd0, co};
    @(posedge clk);
    sb.write_reg(CFG_COUNT_ONLY, {23'd0, co});
    cfg_we <= 1'b0;
  endtask

  function automatic bit [7:0] alphabet_char(int idx);
    if (idx < 26) return 8'(CHAR_UPPER_A + idx);
    if (idx < 52) return 8'(CHAR_LOWER_A + (idx - 26));
    if (idx < 62) return 8'(CHAR_DIGIT_0 + (idx - 52));
    return (idx == 62) ? CHAR_PLUS : CHAR_SLASH;
  endfunction

  // Mostly well-formed texts of a few groups; one in five is damaged.
  task automatic random_text(output int sent);
    request_t q[$];
    request_t r;
    int groups;
    int pads;
    int idx;
    groups = $urandom_range(0, 3);
    pads = $urandom_range(0, 2);
    sent = 0;
    for (int g = 0; g < groups; g++) begin
      for (int k = 0; k < 4; k++) begin
        r.c = (g == groups - 1 && k >= 4 - pads) ? CHAR_PAD : alphabet_char($urandom_range(0, 63));
        r.present = 1'b1;
        r.eot = 1'b0;
        q.push_back(r);
      end
    end
    if ($urandom_range(0, 4) == 0) begin
      r.present = 1'b1;
      r.eot = 1'b0;
      case ($urandom_range(0, 3))
        0: begin
          r.c = 8'($urandom_range(0, 255));
          if (q.size() > 0) q[$urandom_range(0, q.size() - 1)] = r;
          else q.push_back(r);
        end
        1: if (q.size() > 0) void'(q.pop_back());
        2: begin
          r.c = CHAR_PAD;
          q.insert($urandom_range(0, q.size()), r);
        end
        default: begin
          r.c = alphabet_char($urandom_range(0, 63));
          q.push_back(r);
        end
      endcase
    end
    if ($urandom_range(0, 5) == 0) begin
      r.c = 8'($urandom_range(0, 255));
      r.present = 1'b0;
      r.eot = 1'b0;
      q.insert($urandom_range(0, q.size()), r);
    end
    if (q.size() > 0 && q[q.size()-1].present && $urandom_range(0, 1) == 1) begin
      idx = q.size() - 1;
      r = q[idx];
      r.eot = 1'b1;
      q[idx] = r;
    end else begin
      r.c = 8'($urandom_range(0, 255));
      r.present = 1'b0;
      r.eot = 1'b1;
      q.push_back(r);
    end
    foreach (q[i]) begin
      send_item(q[i].c, q[i].present, q[i].eot);
      if (q[i].present || q[i].eot) sent++;
    end
  endtask

  initial begin : stimulus
    bit [23:0] caps[5];
    bit        modes[5];
    int        n;
    int        phase_items;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    configure(24'hffffff, 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);  // empty text
    send_string("TWFu", 1'b1);
    send_string("TQ==", 1'b0);
    send_item("A", 1'b1, 1'b0);                     // data after a padded group
    send_item(8'h00, 1'b0, 1'b1);
    send_string("=TWFu", 1'b1);                     // pad in first place, then no more bytes
    send_string("TQ=A", 1'b1);                      // third-place pad without a fourth
    send_item(8'hff, 1'b0, 1'b0);                   // no character, no end: ignored
    send_item(8'h00, 1'b1, 1'b1);                   // invalid character, closes the text
    send_string("TWF", 1'b1);                       // unfinished group

    caps[0] = 24'd0;
    caps[1] = 24'($urandom_range(1, 12));
    caps[2] = 24'hffffff;
    caps[3] = 24'd5;
    caps[4] = 24'($urandom_range(0, 24'hffffff));
    modes[0] = 1'b0;
    modes[1] = 1'b0;
    modes[2] = 1'b1;
    modes[3] = 1'b1;
    modes[4] = 1'b0;
    for (int p = 0; p < 5; p++) begin
      configure(caps[p], modes[p]);
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      if (p == 1) begin
        // Sink stops for a long stretch while texts keep coming.
        tx_quiet = 1'b1;
        hold_req = 80;
      end
      phase_items = 0;
      while (phase_items < 22) begin
        random_text(n);
        phase_items += n;
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.decoded_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #400000;
    $display("Verification failed");
    $finish;
  end

endmodule
